// File: hw/rtl/bracket_packet_receiver_top_defines.svh
// Assertion macros for the bracket packet receiver.
// Included by bracket_packet_receiver_top; no other dependencies.
`ifndef BRACKET_PACKET_RECEIVER_TOP_DEFINES_SVH
`define BRACKET_PACKET_RECEIVER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bracket packet receiver: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bracket packet receiver: next-cycle check failed");

`endif

// File: hw/rtl/bpr_pkg.sv
// Shared constants and types for the bracket packet receiver.
// No dependencies; imported by bpr_ctrl, the top level and the testbench.
`default_nettype none

package bpr_pkg;

  localparam int unsigned STORE_DEPTH = 128;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
  localparam int unsigned BYTE_W      = 8;

  // Request codes
  localparam logic [1:0] FN_RX   = 2'd0;
  localparam logic [1:0] FN_POLL = 2'd1;
  localparam logic [1:0] FN_ERR  = 2'd2;
  localparam logic [1:0] FN_READ = 2'd3;

  localparam logic [BYTE_W-1:0] OPEN_MARK  = 8'h5B;
  localparam logic [BYTE_W-1:0] CLOSE_MARK = 8'h5D;
  localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STORE_DEPTH - 1);

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [BYTE_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic flag_taken;
    logic packet_ready;
    logic receiving;
    logic rd_zero;     // read_byte forced to zero
  } ctrl_res_t;

endpackage

`default_nettype wire

// File: hw/rtl/bpr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module bpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/bpr_ctrl.sv
// Framing control: packet state, write pointer, ready flag, store requests.
// Depends on bpr_pkg.
`default_nettype none

module bpr_ctrl
  import bpr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire logic [1:0]        func_i,
  input  wire logic [BYTE_W-1:0] data_byte_i,
  input  wire logic [IDX_W-1:0]  read_index_i,
  output mem_req_t               mem_req_o,
  output ctrl_res_t              res_o,
  output logic [IDX_W-1:0]       widx_o
);

  logic             in_pkt_q, in_pkt_d;
  logic             rdy_q, rdy_d;
  logic [IDX_W-1:0] widx_q, widx_d;
  logic             z0_q, z0_d;   // entry 0 still holds its reset zero
  mem_req_t         req;
  logic             taken;

  always_comb begin
    in_pkt_d  = in_pkt_q;
    rdy_d     = rdy_q;
    widx_d    = widx_q;
    req       = '0;
    taken     = 1'b0;
    unique case (func_i)
      FN_RX: begin
        if (!in_pkt_q) begin
          if (data_byte_i == OPEN_MARK && !rdy_q) begin
            in_pkt_d = 1'b1;
            widx_d   = '0;
          end
        end else if (data_byte_i == CLOSE_MARK) begin
          in_pkt_d  = 1'b0;
          rdy_d     = 1'b1;
          req.we    = 1'b1;
          req.waddr = widx_q;
          req.wdata = TERMINATOR;
        end else if (widx_q != LAST_IDX) begin
          req.we    = 1'b1;
          req.waddr = widx_q;
          req.wdata = data_byte_i;
          widx_d    = widx_q + 1'b1;
        end else begin
          // overflow: abort and clear entry 0
          in_pkt_d  = 1'b0;
          widx_d    = '0;
          req.we    = 1'b1;
          req.waddr = '0;
          req.wdata = TERMINATOR;
        end
      end
      FN_POLL: begin
        taken = rdy_q;
        rdy_d = 1'b0;
      end
      FN_ERR: begin
        in_pkt_d  = 1'b0;
        widx_d    = '0;
        req.we    = !rdy_q;
        req.waddr = '0;
        req.wdata = TERMINATOR;
      end
      FN_READ: begin
        req.re    = 1'b1;
        req.raddr = read_index_i;
      end
      default: ;
    endcase
  end

  assign z0_d = z0_q && !(fire_i && req.we && req.waddr == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_pkt_q <= 1'b0;
      rdy_q    <= 1'b0;
      widx_q   <= '0;
      z0_q     <= 1'b1;
    end else begin
      z0_q <= z0_d;
      if (fire_i) begin
        in_pkt_q <= in_pkt_d;
        rdy_q    <= rdy_d;
        widx_q   <= widx_d;
      end
    end
  end

  always_comb begin
    mem_req_o    = req;
    mem_req_o.we = req.we && fire_i;
    mem_req_o.re = req.re && fire_i;
  end

  assign res_o.flag_taken   = taken;
  assign res_o.packet_ready = rdy_d;
  assign res_o.receiving    = in_pkt_d;
  assign res_o.rd_zero      = !req.re || (read_index_i == '0 && z0_q);
  assign widx_o             = widx_q;

endmodule

`default_nettype wire

// File: hw/rtl/bracket_packet_receiver_top.sv
// Bracket packet receiver, top level: control, packet store and result register.
// Depends on bpr_pkg, bpr_ctrl, bpr_ram and bracket_packet_receiver_top_defines.svh.
//
// Frames packets opened by '[' and closed by ']' from a stream of requests
// (received byte, poll-and-clear of the ready flag, error recovery, store
// read). Each request yields exactly one result. A request is accepted
// every cycle while the result register is empty or being emptied in the
// same cycle, so the sustained rate is one request per clock; the result is
// valid in the cycle after acceptance. The packet state (flags and write
// pointer) sits in flops, the payload in a 128 x 8 RAM with a registered
// read port: a store read is issued on acceptance and its data lands
// alongside the result register, and the RAM data only changes when a new
// read request is taken, so it holds while the result is stalled. Entry 0
// reads as zero until first written, tracked by a single flag; no clearing
// pass is needed after reset.
`default_nettype none
`include "bracket_packet_receiver_top_defines.svh"

module bracket_packet_receiver_top
  import bpr_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        func_i,
  input  wire logic [BYTE_W-1:0] data_byte_i,
  input  wire logic [IDX_W-1:0]  read_index_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   flag_taken_o,
  output logic      [BYTE_W-1:0] read_byte_o,
  output logic                   packet_ready_o,
  output logic                   receiving_o
);

  logic             fire;
  mem_req_t         mem_req;
  ctrl_res_t        res;
  ctrl_res_t        res_q;
  logic             out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] ram_rdata;
  logic [IDX_W-1:0] widx;

  // Result register frees up in the cycle it is taken.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  bpr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .func_i       (func_i),
    .data_byte_i  (data_byte_i),
    .read_index_i (read_index_i),
    .mem_req_o    (mem_req),
    .res_o        (res),
    .widx_o       (widx)
  );

  bpr_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (ram_rdata)
  );

  assign out_valid_d = fire || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign flag_taken_o   = res_q.flag_taken;
  assign packet_ready_o = res_q.packet_ready;
  assign receiving_o    = res_q.receiving;
  assign read_byte_o    = res_q.rd_zero ? '0 : ram_rdata;

  // Store writes land either at the write pointer or at entry 0.
  `BPR_ASSERT_NOW(a_waddr_legal, clk_i, rst_ni, mem_req.we, (mem_req.waddr == widx) || (mem_req.waddr == '0))
  // A store read and a store write are never requested together.
  `BPR_ASSERT_NOW(a_no_rw_clash, clk_i, rst_ni, mem_req.we, !mem_req.re)
  // A store request is only issued for an accepted request.
  `BPR_ASSERT_NOW(a_mem_on_fire, clk_i, rst_ni, mem_req.we || mem_req.re, fire)
  // A stalled store read result keeps its RAM read data.
  `BPR_ASSERT_NEXT(a_rdata_hold, clk_i, rst_ni, out_valid_q && !out_ready_i && !res_q.rd_zero, $stable(ram_rdata))

endmodule

`default_nettype wire

// File: verif/bracket_packet_receiver_top_tb.sv
// Self-checking testbench for bracket_packet_receiver_top: directed table, then random packets.
// Depends on bpr_pkg and the RTL of the block; needs no files or arguments at run time.
`default_nettype none

module bracket_packet_receiver_top_tb;
  import bpr_pkg::*;

  // One status word per request, as the block returns it
  typedef struct packed {
    logic              flag_taken;
    logic [BYTE_W-1:0] read_byte;
    logic              packet_ready;
    logic              receiving;
  } rx_status_t;

  // Row of the directed table; res is only meaningful where typed is set
  typedef struct {
    logic [1:0]        f;
    logic [BYTE_W-1:0] b;
    logic [IDX_W-1:0]  idx;
    bit                typed;
    rx_status_t        res;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        func;
  logic [BYTE_W-1:0] data_byte;
  logic [IDX_W-1:0]  read_index;
  logic              out_valid;
  logic              out_ready;
  logic              flag_taken;
  logic [BYTE_W-1:0] read_byte;
  logic              packet_ready;
  logic              receiving;

  // Shadow copy of the framer state
  bit                in_pkt;
  int unsigned       wr_pos;
  bit                ready_pending;
  logic [BYTE_W-1:0] pkt_mem   [STORE_DEPTH];
  bit                mem_valid [STORE_DEPTH];

  rx_status_t awaited_status[$];
  rx_status_t got_status;
  rx_status_t want_status;

  int n_err;
  int n_sent;
  int n_seen;
  int n_closed;
  int n_overflow;
  int n_flag;
  int n_reads;
  int n_recover;

  // Idling controls shared with the receiver process
  bit tx_gaps;
  bit rx_gaps;
  bit hold_rx_req;
  int stall_left;

  // Directed table. Typed rows: after reset, ignored bytes, opening and closing,
  // the ready flag blocking a new '[', poll values and error recovery clearing entry 0.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{FN_POLL, 8'h00,       7'd0,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
    '{FN_READ, 8'h00,       7'd0,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
    '{FN_RX,   8'h00,       7'd127, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
    '{FN_RX,   8'hFF,       7'd0,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
    '{FN_RX,   CLOSE_MARK,  7'd0,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
    '{FN_RX,   OPEN_MARK,   7'd0,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b1}},
    '{FN_RX,   OPEN_MARK,   7'd0,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b1}},
    '{FN_RX,   8'hFF,       7'd5,   1'b0, '0},
    '{FN_RX,   8'h00,       7'd0,   1'b0, '0},
    '{FN_RX,   CLOSE_MARK,  7'd0,   1'b1, '{1'b0, 8'h00, 1'b1, 1'b0}},
    '{FN_READ, 8'h00,       7'd0,   1'b0, '0},
    '{FN_READ, 8'hFF,       7'd3,   1'b0, '0},
    '{FN_RX,   OPEN_MARK,   7'd0,   1'b1, '{1'b0, 8'h00, 1'b1, 1'b0}},
    '{FN_ERR,  8'h00,       7'd0,   1'b1, '{1'b0, 8'h00, 1'b1, 1'b0}},
    '{FN_READ, 8'h00,       7'd0,   1'b0, '0},
    '{FN_POLL, 8'h00,       7'd0,   1'b1, '{1'b1, 8'h00, 1'b0, 1'b0}},
    '{FN_POLL, 8'h00,       7'd0,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
    '{FN_RX,   OPEN_MARK,   7'd0,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b1}},
    '{FN_RX,   8'hA5,       7'd0,   1'b0, '0},
    '{FN_ERR,  8'hFF,       7'd127, 1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
    '{FN_READ, 8'h00,       7'd0,   1'b1, '{1'b0, 8'h00, 1'b0, 1'b0}},
    '{FN_READ, 8'h00,       7'd1,   1'b0, '0},
    '{FN_RX,   OPEN_MARK,   7'd0,   1'b0, '0},
    '{FN_RX,   CLOSE_MARK,  7'd0,   1'b0, '0},
    '{FN_POLL, 8'hFF,       7'd0,   1'b0, '0}
  };

  bracket_packet_receiver_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .func_i         (func),
    .data_byte_i    (data_byte),
    .read_index_i   (read_index),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .flag_taken_o   (flag_taken),
    .read_byte_o    (read_byte),
    .packet_ready_o (packet_ready),
    .receiving_o    (receiving)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got_v,
                                 input logic [BYTE_W-1:0] exp_v);
    n_err++;
    $display("mismatch, %s at result %0d: got %h, expected %h", what, n_seen, got_v, exp_v);
  endtask

  // Advances the shadow state by one request and returns the status word it yields
  task automatic frame_step(input logic [1:0] f, input logic [BYTE_W-1:0] b,
                            input logic [IDX_W-1:0] idx, output rx_status_t r);
    r = '0;
    case (f)
      FN_RX: begin
        if (!in_pkt) begin
          // outside a packet only an unblocked '[' counts
          if (b == OPEN_MARK && !ready_pending) begin
            in_pkt = 1'b1;
            wr_pos = 0;
          end
        end else if (b == CLOSE_MARK) begin
          in_pkt                = 1'b0;
          pkt_mem[wr_pos]       = TERMINATOR;
          mem_valid[wr_pos]     = 1'b1;
          ready_pending         = 1'b1;
          n_closed++;
        end else if (wr_pos < STORE_DEPTH - 1) begin
          pkt_mem[wr_pos]   = b;
          mem_valid[wr_pos] = 1'b1;
          wr_pos++;
        end else begin
          // payload would reach the last entry: abort and drop the byte
          in_pkt     = 1'b0;
          wr_pos     = 0;
          pkt_mem[0] = TERMINATOR;
          n_overflow++;
        end
      end
      FN_POLL: begin
        r.flag_taken  = ready_pending;
        if (ready_pending) n_flag++;
        ready_pending = 1'b0;
      end
      FN_ERR: begin
        in_pkt = 1'b0;
        wr_pos = 0;
        if (!ready_pending) pkt_mem[0] = TERMINATOR;
        n_recover++;
      end
      FN_READ: begin
        if (int'(idx) < STORE_DEPTH) r.read_byte = pkt_mem[idx];
        n_reads++;
      end
      default: ;
    endcase
    r.packet_ready = ready_pending;
    r.receiving    = in_pkt;
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pkt_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 10);
    if (r < 96) return $urandom_range(11, 60);
    return $urandom_range(124, 130);
  endfunction

  // Read index that only ever hits entry 0 or an entry written since reset
  function automatic logic [IDX_W-1:0] pick_index();
    logic [IDX_W-1:0] k;
    int               t;
    for (t = 0; t < 8; t++) begin
      k = (t < 3) ? IDX_W'($urandom_range(0, 8)) : IDX_W'($urandom_range(0, STORE_DEPTH - 1));
      if (mem_valid[k]) return k;
    end
    return '0;
  endfunction

  function automatic logic [BYTE_W-1:0] payload_byte();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(0, 255));
    if (b == CLOSE_MARK) b = OPEN_MARK;
    return b;
  endfunction

  // Offers one request and holds it until taken. Called at a rising edge; returns at
  // the edge where it was taken, or after an idle gap. Acceptance is judged at the
  // falling edge before, where in_ready is settled.
  task automatic push_req(input logic [1:0] f, input logic [BYTE_W-1:0] b,
                          input logic [IDX_W-1:0] idx, input bit typed,
                          input rx_status_t typed_res);
    rx_status_t pred;
    int         g;
    in_valid   <= 1'b1;
    func       <= f;
    data_byte  <= b;
    read_index <= idx;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
    frame_step(f, b, idx, pred);
    awaited_status.push_back(typed ? typed_res : pred);
    n_sent++;
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      g = gap_len();
      in_valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic send_rand(input logic [1:0] f, input logic [BYTE_W-1:0] b);
    push_req(f, b, (f == FN_READ) ? pick_index() : IDX_W'($urandom_range(0, STORE_DEPTH - 1)),
             1'b0, '0);
  endtask

  // Framed packet with random content; closed by ']' or broken off by an error event
  task automatic rand_packet(input int len, input bit closed);
    int i;
    if (ready_pending && (len > 100 || $urandom_range(0, 9) < 8))
      send_rand(FN_POLL, BYTE_W'($urandom_range(0, 255)));
    send_rand(FN_RX, OPEN_MARK);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(0, 29) == 0)
        send_rand($urandom_range(0, 1) ? FN_POLL : FN_READ, BYTE_W'($urandom_range(0, 255)));
      send_rand(FN_RX, payload_byte());
    end
    if (closed) send_rand(FN_RX, CLOSE_MARK);
    else        send_rand(FN_ERR, BYTE_W'($urandom_range(0, 255)));
    repeat ($urandom_range(0, 3)) send_rand(FN_READ, BYTE_W'($urandom_range(0, 255)));
  endtask

  // Sender pause: nothing offered until every status word has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (awaited_status.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls, plus one long hold-off on request from the stimulus
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_rx_req) begin
        hold_rx_req = 1'b0;
        stall_left  = 250;
        out_ready <= 1'b0;
      end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
        stall_left = gap_len() - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Result check at the falling edge, against the oldest awaited status word
  always @(negedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      got_status = '{flag_taken, read_byte, packet_ready, receiving};
      if (awaited_status.size() == 0) begin
        report_mismatch("unexpected result", read_byte, '0);
      end else begin
        want_status = awaited_status.pop_front();
        if (got_status.flag_taken !== want_status.flag_taken)
          report_mismatch("flag_taken", got_status.flag_taken, want_status.flag_taken);
        if (got_status.read_byte !== want_status.read_byte)
          report_mismatch("read_byte", got_status.read_byte, want_status.read_byte);
        if (got_status.packet_ready !== want_status.packet_ready)
          report_mismatch("packet_ready", got_status.packet_ready, want_status.packet_ready);
        if (got_status.receiving !== want_status.receiving)
          report_mismatch("receiving", got_status.receiving, want_status.receiving);
      end
      n_seen++;
    end
  end

  // Main stimulus
  initial begin
    int  i;
    int  r;
    bit  hold_done;
    bit  pause_done;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    func        = FN_RX;
    data_byte   = '0;
    read_index  = '0;
    tx_gaps     = 1'b1;
    rx_gaps     = 1'b1;
    hold_rx_req = 1'b0;
    hold_done   = 1'b0;
    pause_done  = 1'b0;
    in_pkt        = 1'b0;
    wr_pos        = 0;
    ready_pending = 1'b0;
    for (i = 0; i < STORE_DEPTH; i++) begin
      pkt_mem[i]   = '0;
      mem_valid[i] = 1'b0;
    end
    // entry 0 is defined as zero straight out of reset
    mem_valid[0] = 1'b1;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIR_ROWS; i++)
      push_req(dir_tab[i].f, dir_tab[i].b, dir_tab[i].idx, dir_tab[i].typed, dir_tab[i].res);

    // Longest packet that still closes (terminator lands in the last entry),
    // then one a byte longer that overflows, then a read of the last entry
    rand_packet(STORE_DEPTH - 1, 1'b1);
    rand_packet(STORE_DEPTH, 1'b1);
    push_req(FN_READ, 8'hFF, IDX_W'(STORE_DEPTH - 1), 1'b0, '0);

    while (n_sent < 1700) begin
      // idling mode changes every few hundred requests; one mode runs flat out
      case ((n_sent / 300) % 4)
        0:       begin tx_gaps = 1'b1; rx_gaps = 1'b1; end
        1:       begin tx_gaps = 1'b0; rx_gaps = 1'b0; end
        2:       begin tx_gaps = 1'b1; rx_gaps = 1'b0; end
        default: begin tx_gaps = 1'b0; rx_gaps = 1'b1; end
      endcase
      if (!hold_done && n_sent >= 800) begin
        // receiver holds off while the sender keeps offering: the block backs up
        hold_done   = 1'b1;
        tx_gaps     = 1'b0;
        hold_rx_req = 1'b1;
        rand_packet(30, 1'b1);
      end
      if (!pause_done && n_sent >= 1200) begin
        pause_done = 1'b1;
        wait_drain();
      end
      r = $urandom_range(0, 99);
      if (r < 55)      rand_packet(pkt_len(), 1'b1);
      else if (r < 65) rand_packet(pkt_len(), 1'b0);
      else if (r < 80) send_rand(FN_READ, BYTE_W'($urandom_range(0, 255)));
      else if (r < 88) send_rand(FN_POLL, BYTE_W'($urandom_range(0, 255)));
      else             send_rand(2'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
    end

    // drain, then a few more cycles to catch any stray result
    wait_drain();
    repeat (10) @(posedge clk_i);

    $display("Ran %0d requests: %0d packets closed, %0d overflows, %0d error recoveries,",
             n_sent, n_closed, n_overflow, n_recover);
    $display("%0d polls that found a packet waiting, %0d store reads, %0d mismatches.",
             n_flag, n_reads, n_err);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
